[hdl/bblur_pkg.sv]
// Shared types and constants for the 3x3 edge-aware box blur.
// Holds the word structs, the state enum and the sizing constants.
// Depends on nothing; every other file imports it.
package bblur_pkg;

    // Deepest row that the line memories hold.
    localparam int MAX_WIDTH = 1024;
    // Bits of a column index into the line memories.
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    // Bits of a column count, which can equal the row length.
    localparam int CNT_W     = COL_W + 1;

    // Configuration register widths and indexes.
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    typedef enum logic [0:0] {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } t_req_type;

    typedef struct packed {
        logic [0:0] req_type;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [0:0] last_pixel;
    } t_out_word;

    // One stored pixel: red in the top byte, blue in the bottom byte.
    typedef logic [23:0] t_pix;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

[hdl/box_blur_3x3_edge_aware.sv]
// Top level of the streaming 3x3 edge-aware box blur.
// Contains the line memories, window, sequencer and rounding divider.
// Depends on bblur_pkg.
//
// Usage:
//   Pixels enter on the input channel (i_in_valid / o_in_ready / i_in_word) in
//   raster order. Each result word on the output channel (o_out_valid /
//   i_out_ready / o_out_word) is the per-channel mean of a pixel's 3x3
//   neighborhood, counting only neighbors inside the image and rounding half
//   up. Results trail the input by one row and one column; after the last
//   pixel, image_width flush words drain the final row, and the very last
//   result carries last_pixel. Words that fall outside that order give nothing.
//   The configuration port writes image_width or image_height at any edge with
//   i_cfg_we high; a write restarts the image.
// Sequence:
//   One word is worked on at a time. A word that gives no result passes
//   through the memory read state and back to idle; a dropped word stays in
//   idle. Each result adds a state for the neighborhood sum and count, the
//   bit-serial divider that forms the eight quotient bits, and a state that
//   loads the output register.
// Reset and stall:
//   Synchronous active-low reset clears the counters, the sequencer and the
//   output valid flag; the line memories need no clearing, as stale entries
//   are never counted. While the receiver stalls, the finished word waits in
//   the output register; the next word is taken and worked on up to ST_OUT.
module box_blur_3x3_edge_aware (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bblur_pkg::t_in_word           i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bblur_pkg::t_out_word          o_out_word,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bblur_pkg::*;

    // Configuration and position counters.
    logic [CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [CFG_HEIGHT_W-1:0] r_cfg_height;
    logic [COL_W-1:0]        r_in_col;
    logic [CFG_HEIGHT_W-1:0] r_in_row;
    logic [COL_W-1:0]        r_flush_col;

    // Sequencer.
    t_state r_state, n_state;

    // The word being worked on.
    logic             r_flush;
    t_pix             r_px;
    logic [COL_W-1:0] r_col;
    logic             r_col_last;
    logic             r_row_ge1;
    logic             r_row_ge2;

    // Line memories and their registered read data.
    t_pix mem_upper [MAX_WIDTH];
    t_pix mem_middle [MAX_WIDTH];
    t_pix r_up_rd;
    t_pix r_mid_rd;

    // Window: [row r-2, r-1, r][column c-2, c-1, c], plus presence masks.
    t_pix       r_win [3][3];
    logic [2:0] r_row_ok;
    logic [2:0] r_col_ok;

    // Result bookkeeping.
    logic r_need_b;   // the right-edge result still has to be made
    logic r_first;    // the current result leaves out column c-2
    logic r_last;

    // Divider, one lane per color.
    logic [4:0] r_rem [3];
    logic [7:0] r_dq  [3];
    logic [4:0] r_divisor;
    logic [2:0] r_div_cnt;

    // Output register.
    logic      r_out_valid;
    t_out_word r_out;

    // Combinational helpers.
    logic [CNT_W-1:0]        w_eff;
    logic [CFG_HEIGHT_W-1:0] h_eff;
    logic                    in_acc;
    logic                    drop;
    logic [COL_W-1:0]        acc_col;
    logic [CNT_W-1:0]        col_inc;
    logic                    out_free;
    logic [11:0]             sum [3];
    logic [3:0]              cnt;
    logic [5:0]              trial [3];
    logic                    qbit [3];

    // Effective sizes: width clamped to 1..MAX_WIDTH, zero height taken as one.
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = CNT_W'(r_cfg_width);
        end
        h_eff = (r_cfg_height == '0) ? CFG_HEIGHT_W'(1) : r_cfg_height;
    end

    assign in_acc  = i_in_valid && o_in_ready;
    // A flush before the last pixel, or a pixel during the drain, is dropped.
    assign drop    = (i_in_word.req_type == REQ_FLUSH) ? (r_in_row < h_eff)
                                                       : (r_in_row >= h_eff);
    assign acc_col = (i_in_word.req_type == REQ_FLUSH) ? r_flush_col : r_in_col;
    assign col_inc = CNT_W'(r_col) + CNT_W'(1);
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer: state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and handshake.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !drop) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_row_ge1 && (r_col != '0 || r_col_last)) begin
                    n_state = ST_SUM;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SUM: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_div_cnt == 3'd7) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = r_need_b ? ST_SUM : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Line memories: read at acceptance, written back in the read-data cycle.
    // The next read is issued only from the idle state after the write, so no
    // forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ && !r_flush) begin
            mem_upper[r_col] <= r_mid_rd;
        end
        if (in_acc) begin
            r_up_rd <= mem_upper[acc_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ && !r_flush) begin
            mem_middle[r_col] <= r_px;
        end
        if (in_acc) begin
            r_mid_rd <= mem_middle[acc_col];
        end
    end

    // Configuration and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_WIDTH_W'(1);
            r_cfg_height <= CFG_HEIGHT_W'(1);
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_flush_col  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_flush_col <= '0;
        end else if (r_state == ST_READ) begin
            if (r_flush) begin
                if (col_inc >= w_eff) begin
                    r_flush_col <= '0;
                    r_in_row    <= '0;
                    r_in_col    <= '0;
                end else begin
                    r_flush_col <= col_inc[COL_W-1:0];
                end
            end else begin
                if (col_inc >= w_eff) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + CFG_HEIGHT_W'(1);
                end else begin
                    r_in_col <= col_inc[COL_W-1:0];
                end
            end
        end
    end

    // Neighborhood sum and count over the present window entries.
    always_comb begin
        logic ok;
        cnt = '0;
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ok = r_row_ok[i] && r_col_ok[j] && (j != 0 || !r_first);
                if (ok) begin
                    cnt = cnt + 4'd1;
                    for (int ch = 0; ch < 3; ch++) begin
                        sum[ch] = sum[ch] + 12'(r_win[i][j][23 - 8 * ch -: 8]);
                    end
                end
            end
        end
    end

    // One restoring step per lane: shift in the next dividend bit and try.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            trial[ch] = {r_rem[ch], r_dq[ch][7]};
            qbit[ch]  = trial[ch] >= 6'(r_divisor);
        end
    end

    // Item registers, window, result bookkeeping and divider.
    always_ff @(posedge i_clk) begin
        logic [12:0] dividend;
        if (!i_rst_n) begin
            r_need_b  <= 1'b0;
            r_first   <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_flush    <= (i_in_word.req_type == REQ_FLUSH);
                        r_px       <= (i_in_word.req_type == REQ_FLUSH) ? t_pix'(0) :
                                      {i_in_word.in_red, i_in_word.in_green,
                                       i_in_word.in_blue};
                        r_col      <= acc_col;
                        r_col_last <= (CNT_W'(acc_col) + CNT_W'(1)) == w_eff;
                        if (i_in_word.req_type == REQ_FLUSH) begin
                            r_row_ge1 <= 1'b1;
                            r_row_ge2 <= (h_eff >= CFG_HEIGHT_W'(2));
                        end else begin
                            r_row_ge1 <= (r_in_row >= CFG_HEIGHT_W'(1));
                            r_row_ge2 <= (r_in_row >= CFG_HEIGHT_W'(2));
                        end
                    end
                end
                ST_READ: begin
                    for (int i = 0; i < 3; i++) begin
                        r_win[i][0] <= r_win[i][1];
                        r_win[i][1] <= r_win[i][2];
                    end
                    r_win[0][2] <= r_up_rd;
                    r_win[1][2] <= r_mid_rd;
                    r_win[2][2] <= r_px;
                    r_row_ok    <= {!r_flush, 1'b1, r_row_ge2};
                    r_col_ok    <= {1'b1, r_col != '0, r_col >= COL_W'(2)};
                    r_last      <= r_flush;
                    // Interior result first when there is one, then the
                    // right-edge result at the end of a row.
                    if (r_col != '0) begin
                        r_first  <= 1'b0;
                        r_need_b <= r_col_last;
                    end else begin
                        r_first  <= 1'b1;
                        r_need_b <= 1'b0;
                    end
                end
                ST_SUM: begin
                    // Quotient of (2*sum + n) / (2*n) fits eight bits, so the
                    // top five dividend bits already lie below the divisor.
                    for (int ch = 0; ch < 3; ch++) begin
                        dividend  = {sum[ch], 1'b0} + 13'(cnt);
                        r_rem[ch] <= dividend[12:8];
                        r_dq[ch]  <= dividend[7:0];
                    end
                    r_divisor <= {cnt, 1'b0};
                    r_div_cnt <= '0;
                end
                ST_DIV: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_rem[ch] <= qbit[ch] ? 5'(trial[ch] - 6'(r_divisor))
                                              : trial[ch][4:0];
                        r_dq[ch]  <= {r_dq[ch][6:0], qbit[ch]};
                    end
                    r_div_cnt <= r_div_cnt + 3'd1;
                end
                ST_OUT: begin
                    if (out_free && r_need_b) begin
                        r_need_b <= 1'b0;
                        r_first  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register: holds a finished word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out.out_red    <= r_dq[0];
            r_out.out_green  <= r_dq[1];
            r_out.out_blue   <= r_dq[2];
            // Only the right-edge result of a flush word closes the image.
            r_out.last_pixel <= r_last && (r_first || !r_need_b) && r_col_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // A word that is not dropped always moves on to the memory read cycle.
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !drop) |=> (r_state == ST_READ))
        else $error("accepted word did not start a memory read");

    // A new output word only appears from the output-load state.
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("output register loaded outside the output-load state");

    // Column counters stay inside the active row while waiting for input.
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |->
            ((CNT_W'(r_in_col) < w_eff) && (CNT_W'(r_flush_col) < w_eff)))
        else $error("column counter beyond the configured width");

endmodule
